// ===== rtl/core/rqts_pkg.sv =====
package rqts_pkg;

  // default queue size
  localparam int QUEUE_DEPTH = 16;

  // field widths
  localparam int TASK_W  = 8;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 16;

  // policy codes
  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_SJF  = 2'd1;
  localparam logic [1:0] MODE_PR   = 2'd2;
  localparam logic [1:0] MODE_RR   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // command codes
  localparam logic CMD_ENQ  = 1'b0;
  localparam logic CMD_DISP = 1'b1;

  // register indexes
  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  // reset value of the quantum
  localparam logic [BURST_W-1:0] QUANTUM_RST = 16'd10;

  // shared unit operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_BURST = 2'd0;  // candidate burst < best burst
  localparam alu_op_t ALU_PRIO  = 2'd1;  // best priority < candidate priority
  localparam alu_op_t ALU_QUANT = 2'd2;  // quantum < best burst, diff = burst - quantum

  // one queue entry
  typedef struct packed {
    logic [TASK_W-1:0]  task_id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

  typedef struct packed {
    alu_op_t            op;
    entry_t             cand;
    entry_t             best;
    logic [BURST_W-1:0] quantum;
  } alu_req_t;

  typedef struct packed {
    logic               lt;
    logic [BURST_W-1:0] diff;
  } alu_rsp_t;

endpackage

// ===== rtl/core/rqts_ram.sv =====
module rqts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rqts_alu.sv =====
module rqts_alu (
  input  rqts_pkg::alu_req_t req,
  output rqts_pkg::alu_rsp_t rsp
);

  logic [rqts_pkg::BURST_W-1:0] opa;
  logic [rqts_pkg::BURST_W-1:0] opb;

  // operand select
  always_comb begin
    case (req.op)
      rqts_pkg::ALU_BURST: begin
        opa = req.cand.burst;
        opb = req.best.burst;
      end
      rqts_pkg::ALU_PRIO: begin
        opa = rqts_pkg::BURST_W'(req.best.prio);
        opb = rqts_pkg::BURST_W'(req.cand.prio);
      end
      rqts_pkg::ALU_QUANT: begin
        opa = req.quantum;
        opb = req.best.burst;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // compare and subtract
  assign rsp.lt   = (opa < opb);
  assign rsp.diff = opb - opa;

endmodule

// ===== rtl/core/ready_queue_task_selector.sv =====
// enqueue: the accepted item is written to the queue in S_START, then the result waits in S_FINISH
// dispatch: after S_START, one entry per cycle is scanned through the queue memory
//   read port, then from S_SHIFT_GO the tail behind the chosen entry closes up one entry per cycle
//   in S_SHIFT; S_FINAL pops or requeues the chosen entry and S_FINISH holds the result
// one item at a time; in_stall stays high until the result is in the output register
// reset empties the queue (occupancy zero), sets FIFO policy and quantum 10; memory not cleared
module ready_queue_task_selector #(
  parameter int QUEUE_DEPTH = rqts_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [rqts_pkg::TASK_W-1:0]   in_task_id,
  input  logic [rqts_pkg::PRIO_W-1:0]   in_task_priority,
  input  logic [rqts_pkg::BURST_W-1:0]  in_burst_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [rqts_pkg::TASK_W-1:0]   out_granted_task,
  output logic [rqts_pkg::BURST_W-1:0]  out_run_time,
  output logic                          out_requeued,
  output logic [rqts_pkg::BURST_W-1:0]  out_remaining_burst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rqts_pkg::BURST_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = $bits(rqts_pkg::entry_t);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_START    = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT_GO = 3'd3;
  localparam logic [2:0] S_SHIFT    = 3'd4;
  localparam logic [2:0] S_FINAL    = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             occ_r, occ_nxt;
  logic [IDX_W-1:0]             k_r, k_nxt;
  logic [IDX_W-1:0]             best_idx_r, best_idx_nxt;
  rqts_pkg::entry_t             best_r, best_nxt;
  logic [1:0]                   policy_r;
  logic [rqts_pkg::BURST_W-1:0] quantum_r;

  // latched item
  logic                         cmd_r;
  rqts_pkg::entry_t             item_r;

  // pending result
  logic [1:0]                   res_status_r, res_status_nxt;
  logic [rqts_pkg::TASK_W-1:0]  res_task_r, res_task_nxt;
  logic [rqts_pkg::BURST_W-1:0] res_run_r, res_run_nxt;
  logic                         res_req_r, res_req_nxt;
  logic [rqts_pkg::BURST_W-1:0] res_rem_r, res_rem_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_load;

  // memory ports
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  rqts_pkg::entry_t             mem_wdata;
  logic [IDX_W-1:0]             mem_raddr;
  logic [ENT_W-1:0]             mem_rdata;
  rqts_pkg::entry_t             cand;

  rqts_pkg::alu_req_t           alu_req;
  rqts_pkg::alu_rsp_t           alu_rsp;

  logic                         in_accept;
  logic [CNT_W-1:0]             last_cnt;
  logic                         scan_last;
  logic                         take;
  logic                         requeue;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cand      = rqts_pkg::entry_t'(mem_rdata);
  assign last_cnt  = occ_r - CNT_W'(1);
  assign scan_last = (CNT_W'(k_r) == last_cnt);
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  rqts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared compare / subtract unit
  always_comb begin
    alu_req.cand    = cand;
    alu_req.best    = best_r;
    alu_req.quantum = quantum_r;
    if (state_r == S_FINAL) begin
      alu_req.op = rqts_pkg::ALU_QUANT;
    end else if (policy_r == rqts_pkg::MODE_PR) begin
      alu_req.op = rqts_pkg::ALU_PRIO;
    end else begin
      alu_req.op = rqts_pkg::ALU_BURST;
    end
  end

  rqts_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // first entry always taken; later ones only on a strict win, and only under SJF or PR policy
  assign take = (k_r == '0) ||
                (alu_rsp.lt && ((policy_r == rqts_pkg::MODE_SJF) ||
                                (policy_r == rqts_pkg::MODE_PR)));
  assign requeue = (policy_r == rqts_pkg::MODE_RR) && alu_rsp.lt;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    k_nxt          = k_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    res_status_nxt = res_status_r;
    res_task_nxt   = res_task_r;
    res_run_nxt    = res_run_r;
    res_req_nxt    = res_req_r;
    res_rem_nxt    = res_rem_r;
    mem_we         = 1'b0;
    mem_waddr      = occ_r[IDX_W-1:0];
    mem_wdata      = item_r;
    mem_raddr      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_status_nxt = rqts_pkg::ST_OK;
        res_task_nxt   = '0;
        res_run_nxt    = '0;
        res_req_nxt    = 1'b0;
        res_rem_nxt    = '0;
        k_nxt          = '0;
        if (cmd_r == rqts_pkg::CMD_ENQ) begin
          state_nxt = S_FINISH;
          if (occ_r == CNT_W'(QUEUE_DEPTH)) begin
            res_status_nxt = rqts_pkg::ST_FULL;
          end else begin
            mem_we  = 1'b1;
            occ_nxt = occ_r + CNT_W'(1);
          end
        end else if (occ_r == '0) begin
          res_status_nxt = rqts_pkg::ST_EMPTY;
          state_nxt      = S_FINISH;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // entry k_r is on the read port; fetch the next
        mem_raddr = IDX_W'({1'b0, k_r} + (IDX_W + 1)'(1));
        if (take) begin
          best_nxt     = cand;
          best_idx_nxt = k_r;
        end
        if (scan_last) begin
          state_nxt = S_SHIFT_GO;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_SHIFT_GO: begin
        mem_raddr = IDX_W'({1'b0, best_idx_r} + (IDX_W + 1)'(1));
        k_nxt     = best_idx_r;
        if (CNT_W'(best_idx_r) == last_cnt) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // close up: entry k_r+1 moves down to k_r
        mem_we    = 1'b1;
        mem_waddr = k_r;
        mem_wdata = cand;
        mem_raddr = IDX_W'({1'b0, k_r} + (IDX_W + 1)'(2));
        if ((CNT_W'(k_r) + CNT_W'(1)) == last_cnt) begin
          state_nxt = S_FINAL;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_FINAL: begin
        res_status_nxt = rqts_pkg::ST_OK;
        res_task_nxt   = best_r.task_id;
        if (requeue) begin
          mem_we          = 1'b1;
          mem_waddr       = last_cnt[IDX_W-1:0];
          mem_wdata       = best_r;
          mem_wdata.burst = alu_rsp.diff;
          res_run_nxt     = quantum_r;
          res_req_nxt     = 1'b1;
          res_rem_nxt     = alu_rsp.diff;
        end else begin
          occ_nxt     = last_cnt;
          res_run_nxt = best_r.burst;
          res_req_nxt = 1'b0;
          res_rem_nxt = '0;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      policy_r    <= rqts_pkg::MODE_FIFO;
      quantum_r   <= rqts_pkg::QUANTUM_RST;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == rqts_pkg::CFG_POLICY)) begin
        policy_r <= cfg_data[1:0];
      end
      if (cfg_we && (cfg_index == rqts_pkg::CFG_QUANTUM)) begin
        quantum_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    res_status_r <= res_status_nxt;
    res_task_r   <= res_task_nxt;
    res_run_r    <= res_run_nxt;
    res_req_r    <= res_req_nxt;
    res_rem_r    <= res_rem_nxt;
    if (in_accept) begin
      cmd_r         <= in_command;
      item_r.task_id <= in_task_id;
      item_r.prio    <= in_task_priority;
      item_r.burst   <= in_burst_length;
    end
    if (out_load) begin
      out_status          <= res_status_r;
      out_granted_task    <= res_task_r;
      out_run_time        <= res_run_r;
      out_requeued        <= res_req_r;
      out_remaining_burst <= res_rem_r;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (occ_r != '0))
    else $error("scan on empty queue");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FINISH))
    else $error("result shown outside finish state");

  a_final_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FINAL) && !requeue) |=> (occ_r == $past(occ_r) - CNT_W'(1)))
    else $error("dispatch did not remove an entry");

  a_requeue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_requeued) |-> (out_remaining_burst != '0))
    else $error("requeued task with no burst left");

endmodule
